// ----- hw/rtl/ocf_pkg.sv -----
// ----------------------------------------------------------------------------
// ocf_pkg: shared types and constants of the orbit camera follow block
// Payload structures, register indexes, micro-op codes and fixed constants.
// ----------------------------------------------------------------------------
package ocf_pkg;

    localparam int IN_W  = 208;
    localparam int OUT_W = 240;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [15:0] DIST_IDLE    = 16'd1280;
    localparam logic [15:0] DIST_RUN     = 16'd1536;
    localparam logic [15:0] DIST_JUMP    = 16'd1792;
    localparam logic [32:0] RUN_SQ_LIMIT = 33'd1048576;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [29:0] EXP_F0       = 30'd1073479712;
    localparam int          EXP_STEPS    = 24;
    localparam logic [16:0] SIN_C1       = 17'd102944;
    localparam logic [16:0] SIN_C2       = 17'd42155;
    localparam logic [16:0] SIN_C3       = 17'd4747;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    typedef enum logic [2:0] {
        REG_MOUSE_SENS_X    = 3'd0,
        REG_MOUSE_SENS_Y    = 3'd1,
        REG_STICK_SENS_X    = 3'd2,
        REG_STICK_SENS_Y    = 3'd3,
        REG_PITCH_LOW       = 3'd4,
        REG_PITCH_HIGH      = 3'd5,
        REG_SPRING_RATE     = 3'd6,
        REG_MANUAL_DISTANCE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [12:0] mouse_sens_x;
        logic signed [12:0] mouse_sens_y;
        logic signed [15:0] stick_sens_x;
        logic signed [15:0] stick_sens_y;
        logic signed [15:0] pitch_low;
        logic signed [15:0] pitch_high;
        logic        [15:0] spring_rate;
        logic        [15:0] manual_distance;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic        [15:0] frame_time;
        logic               has_movement;
        logic               grounded;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
        logic        [15:0] yaw_out;
        logic signed [15:0] pitch_out;
        logic        [15:0] distance_out;
    } out_item_t;

    // micro-op sequence of one frame
    typedef enum logic [4:0] {
        OP_MX, OP_SX1, OP_SX2, OP_MY, OP_SY1, OP_SY2,
        OP_VX, OP_VZ, OP_RQ, OP_EE, OP_EF, OP_DF,
        OP_T2, OP_TI, OP_TM, OP_TS,
        OP_O1, OP_O2, OP_O3, OP_O4, OP_O5
    } op_t;

endpackage

// ----- hw/rtl/ocf_mul.sv -----
// ----------------------------------------------------------------------------
// ocf_mul: shared signed multiplier
// One registered signed product, loaded when enabled.
// ----------------------------------------------------------------------------
module ocf_mul (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [ocf_pkg::MUL_A_W-1:0] a,
    input  logic signed [ocf_pkg::MUL_B_W-1:0] b,
    output logic signed [ocf_pkg::MUL_P_W-1:0] p
);

    logic signed [ocf_pkg::MUL_P_W-1:0] p_reg;

    // register the product
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/ocf_core.sv -----
// ----------------------------------------------------------------------------
// ocf_core: camera update sequencer
// Steps one frame through angle, distance, exponential, sine and offset
// micro-ops, each a product on the shared multiplier plus its write-back.
// ----------------------------------------------------------------------------
module ocf_core #(
    parameter int unsigned HEAD_HEIGHT     = 448,
    parameter int unsigned TRIG_TABLE_BITS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  ocf_pkg::in_item_t   item,
    input  ocf_pkg::cfg_t       cfg,
    input  logic                dist_load,
    input  logic [15:0]         dist_load_val,
    input  logic                out_free,
    output logic                ready,
    output logic                done,
    output ocf_pkg::out_item_t  result
);

    localparam int AW = ocf_pkg::MUL_A_W;
    localparam int BW = ocf_pkg::MUL_B_W;
    localparam int PW = ocf_pkg::MUL_P_W;
    localparam int DROP = 16 - TRIG_TABLE_BITS;
    localparam logic [16:0] ANG_HALF = 17'(1) << (DROP - 1);
    localparam logic [15:0] ANG_MASK = 16'hFFFF << DROP;
    localparam logic signed [33:0] HEAD_Q16 = 34'(HEAD_HEIGHT * 256);
    localparam logic [4:0] EXP_LAST = 5'(ocf_pkg::EXP_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WB    = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    ocf_pkg::op_t op_reg, op_next;
    logic [4:0] k_reg, k_next;
    logic [1:0] j_reg, j_next;

    ocf_pkg::in_item_t item_reg;
    logic        [15:0] yaw_reg, yaw_next;
    logic signed [15:0] pitch_reg, pitch_next;
    logic        [15:0] dist_reg, dist_next;
    logic        [15:0] desired_reg, desired_next;
    logic signed [29:0] mx_reg, mx_next;
    logic signed [35:0] tmp_reg, tmp_next;
    logic        [23:0] q_reg, q_next;
    logic        [30:0] e_reg, e_next;
    logic        [29:0] f_reg, f_next;
    logic        [16:0] t2_reg, t2_next;
    logic        [16:0] mid_reg, mid_next;
    logic signed [33:0] offx_reg, offx_next;
    logic signed [33:0] offy_reg, offy_next;
    logic signed [33:0] offz_reg, offz_next;
    logic signed [17:0] sin_reg [4];

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] p_r8, p_r12, p_r16, p_r24, p_r30;
    logic signed [30:0]   dsum;
    logic signed [31:0]   psum;
    logic        [32:0]   vsq;
    logic signed [16:0]   diff;
    logic        [15:0]   ang, ang_q;
    logic        [16:0]   ang_sum;
    logic        [15:0]   tq;
    logic        [16:0]   t_val;
    logic signed [17:0]   s_val;
    logic signed [33:0]   hy;

    ocf_mul u_mul (
        .aclk (aclk),
        .en   (state_reg == ST_ISSUE),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // rounded views of the product
    assign p_r8  = (mul_p + (PW'(1) <<< 7))  >>> 8;
    assign p_r12 = (mul_p + (PW'(1) <<< 11)) >>> 12;
    assign p_r16 = (mul_p + (PW'(1) <<< 15)) >>> 16;
    assign p_r24 = (mul_p + (PW'(1) <<< 23)) >>> 24;
    assign p_r30 = (mul_p + (PW'(1) <<< 29)) >>> 30;

    assign dsum = 31'(mx_reg) + 31'(p_r30);
    assign psum = 32'(pitch_reg) + 32'(dsum);
    assign vsq  = tmp_reg[32:0] + mul_p[32:0];
    assign diff = $signed({1'b0, desired_reg}) - $signed({1'b0, dist_reg});

    // quantize the selected angle and fold it into the first quadrant
    always_comb begin
        case (j_reg)
            2'd0:    ang = yaw_reg;
            2'd1:    ang = yaw_reg + ocf_pkg::QUARTER_TURN;
            2'd2:    ang = pitch_reg;
            default: ang = pitch_reg + ocf_pkg::QUARTER_TURN;
        endcase
        ang_sum = {1'b0, ang} + ANG_HALF;
        ang_q   = ang_sum[15:0] & ANG_MASK;
        tq      = {ang_q[13:0], 2'b00};
        t_val   = ang_q[14] ? (17'h10000 - {1'b0, tq}) : {1'b0, tq};
        s_val   = ang_q[15] ? -$signed({1'b0, p_r16[16:0]}) : $signed({1'b0, p_r16[16:0]});
    end

    // select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            ocf_pkg::OP_MX:  begin mul_a = AW'(item_reg.mouse_dx); mul_b = BW'(cfg.mouse_sens_x); end
            ocf_pkg::OP_SX1: begin mul_a = AW'(item_reg.stick_x);  mul_b = BW'(cfg.stick_sens_x); end
            ocf_pkg::OP_MY:  begin mul_a = AW'(item_reg.mouse_dy); mul_b = BW'(cfg.mouse_sens_y); end
            ocf_pkg::OP_SY1: begin mul_a = AW'(item_reg.stick_y);  mul_b = BW'(cfg.stick_sens_y); end
            ocf_pkg::OP_SX2, ocf_pkg::OP_SY2: begin
                mul_a = tmp_reg;
                mul_b = BW'(item_reg.frame_time);
            end
            ocf_pkg::OP_VX:  begin mul_a = AW'(item_reg.vel_x); mul_b = BW'(item_reg.vel_x); end
            ocf_pkg::OP_VZ:  begin mul_a = AW'(item_reg.vel_z); mul_b = BW'(item_reg.vel_z); end
            ocf_pkg::OP_RQ:  begin
                mul_a = AW'(cfg.spring_rate);
                mul_b = BW'(item_reg.frame_time);
            end
            ocf_pkg::OP_EE:  begin mul_a = AW'(e_reg); mul_b = BW'(f_reg); end
            ocf_pkg::OP_EF:  begin mul_a = AW'(f_reg); mul_b = BW'(f_reg); end
            ocf_pkg::OP_DF:  begin mul_a = AW'(diff); mul_b = BW'(ocf_pkg::ONE_Q30 - e_reg); end
            ocf_pkg::OP_T2:  begin mul_a = AW'(t_val); mul_b = BW'(t_val); end
            ocf_pkg::OP_TI:  begin mul_a = AW'(ocf_pkg::SIN_C3); mul_b = BW'(t2_reg); end
            ocf_pkg::OP_TM:  begin mul_a = AW'(mid_reg); mul_b = BW'(t2_reg); end
            ocf_pkg::OP_TS:  begin mul_a = AW'(t_val); mul_b = BW'(mid_reg); end
            ocf_pkg::OP_O1:  begin mul_a = AW'(sin_reg[0]); mul_b = BW'(sin_reg[3]); end
            ocf_pkg::OP_O3:  begin mul_a = AW'(sin_reg[1]); mul_b = BW'(sin_reg[3]); end
            ocf_pkg::OP_O2, ocf_pkg::OP_O4: begin
                mul_a = tmp_reg;
                mul_b = BW'(dist_reg);
            end
            ocf_pkg::OP_O5:  begin mul_a = AW'(sin_reg[2]); mul_b = BW'(dist_reg); end
            default: ;
        endcase
    end

    // sequencer and write-back
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        yaw_next     = yaw_reg;
        pitch_next   = pitch_reg;
        dist_next    = dist_reg;
        desired_next = desired_reg;
        mx_next      = mx_reg;
        tmp_next     = tmp_reg;
        q_next       = q_reg;
        e_next       = e_reg;
        f_next       = f_reg;
        t2_next      = t2_reg;
        mid_next     = mid_reg;
        offx_next    = offx_reg;
        offy_next    = offy_reg;
        offz_next    = offz_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start && item.frame_time != 16'd0) begin
                    state_next = ST_ISSUE;
                    op_next    = ocf_pkg::OP_MX;
                end
                if (dist_load) begin
                    dist_next = dist_load_val;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                state_next = ST_ISSUE;
                case (op_reg)
                    ocf_pkg::OP_MX: begin
                        mx_next = 30'(mul_p);
                        op_next = ocf_pkg::OP_SX1;
                    end
                    ocf_pkg::OP_SX1: begin
                        tmp_next = 36'(mul_p);
                        op_next  = ocf_pkg::OP_SX2;
                    end
                    ocf_pkg::OP_SX2: begin
                        yaw_next = yaw_reg + dsum[15:0];
                        op_next  = ocf_pkg::OP_MY;
                    end
                    ocf_pkg::OP_MY: begin
                        mx_next = 30'(mul_p);
                        op_next = ocf_pkg::OP_SY1;
                    end
                    ocf_pkg::OP_SY1: begin
                        tmp_next = 36'(mul_p);
                        op_next  = ocf_pkg::OP_SY2;
                    end
                    ocf_pkg::OP_SY2: begin
                        // clamp, low limit first
                        if (psum < 32'(cfg.pitch_low)) begin
                            pitch_next = cfg.pitch_low;
                        end else if (psum > 32'(cfg.pitch_high)) begin
                            pitch_next = cfg.pitch_high;
                        end else begin
                            pitch_next = psum[15:0];
                        end
                        op_next = ocf_pkg::OP_VX;
                    end
                    ocf_pkg::OP_VX: begin
                        tmp_next = 36'(mul_p);
                        op_next  = ocf_pkg::OP_VZ;
                    end
                    ocf_pkg::OP_VZ: begin
                        if (cfg.manual_distance != 16'd0) begin
                            desired_next = cfg.manual_distance;
                        end else if (!item_reg.has_movement) begin
                            desired_next = ocf_pkg::DIST_IDLE;
                        end else if (!item_reg.grounded) begin
                            desired_next = ocf_pkg::DIST_JUMP;
                        end else if (vsq > ocf_pkg::RUN_SQ_LIMIT) begin
                            desired_next = ocf_pkg::DIST_RUN;
                        end else begin
                            desired_next = ocf_pkg::DIST_IDLE;
                        end
                        op_next = ocf_pkg::OP_RQ;
                    end
                    ocf_pkg::OP_RQ: begin
                        if (cfg.spring_rate == 16'd0) begin
                            // snap to the desired distance
                            dist_next = desired_reg;
                            j_next    = 2'd0;
                            op_next   = ocf_pkg::OP_T2;
                        end else begin
                            q_next  = p_r12[23:0];
                            e_next  = ocf_pkg::ONE_Q30;
                            f_next  = ocf_pkg::EXP_F0;
                            k_next  = 5'd0;
                            op_next = ocf_pkg::OP_EE;
                        end
                    end
                    ocf_pkg::OP_EE: begin
                        if (q_reg[k_reg]) begin
                            e_next = p_r30[30:0];
                        end
                        op_next = ocf_pkg::OP_EF;
                    end
                    ocf_pkg::OP_EF: begin
                        f_next = p_r30[29:0];
                        k_next = k_reg + 5'd1;
                        op_next = (k_reg == EXP_LAST) ? ocf_pkg::OP_DF : ocf_pkg::OP_EE;
                    end
                    ocf_pkg::OP_DF: begin
                        dist_next = dist_reg + p_r30[15:0];
                        j_next    = 2'd0;
                        op_next   = ocf_pkg::OP_T2;
                    end
                    ocf_pkg::OP_T2: begin
                        t2_next = p_r16[16:0];
                        op_next = ocf_pkg::OP_TI;
                    end
                    ocf_pkg::OP_TI: begin
                        mid_next = ocf_pkg::SIN_C2 - p_r16[16:0];
                        op_next  = ocf_pkg::OP_TM;
                    end
                    ocf_pkg::OP_TM: begin
                        mid_next = ocf_pkg::SIN_C1 - p_r16[16:0];
                        op_next  = ocf_pkg::OP_TS;
                    end
                    ocf_pkg::OP_TS: begin
                        j_next  = j_reg + 2'd1;
                        op_next = (j_reg == 2'd3) ? ocf_pkg::OP_O1 : ocf_pkg::OP_T2;
                    end
                    ocf_pkg::OP_O1, ocf_pkg::OP_O3: begin
                        tmp_next = 36'(mul_p);
                        op_next  = (op_reg == ocf_pkg::OP_O1) ? ocf_pkg::OP_O2
                                                               : ocf_pkg::OP_O4;
                    end
                    ocf_pkg::OP_O2: begin
                        offx_next = 34'(p_r24);
                        op_next   = ocf_pkg::OP_O3;
                    end
                    ocf_pkg::OP_O4: begin
                        offz_next = 34'(p_r24);
                        op_next   = ocf_pkg::OP_O5;
                    end
                    ocf_pkg::OP_O5: begin
                        offy_next  = 34'(p_r8);
                        state_next = ST_DONE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and angle/distance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= ocf_pkg::OP_MX;
            k_reg     <= '0;
            j_reg     <= '0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
            dist_reg  <= ocf_pkg::DIST_IDLE;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
            dist_reg  <= dist_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            item_reg <= item;
        end
        desired_reg <= desired_next;
        mx_reg      <= mx_next;
        tmp_reg     <= tmp_next;
        q_reg       <= q_next;
        e_reg       <= e_next;
        f_reg       <= f_next;
        t2_reg      <= t2_next;
        mid_reg     <= mid_next;
        offx_reg    <= offx_next;
        offy_reg    <= offy_next;
        offz_reg    <= offz_next;
        if (state_reg == ST_WB && op_reg == ocf_pkg::OP_TS) begin
            sin_reg[j_reg] <= s_val;
        end
    end

    // assemble the result
    always_comb begin
        hy                  = 34'(sat32(34'(item_reg.target_y) + HEAD_Q16));
        result.look_x       = item_reg.target_x;
        result.look_y       = hy[31:0];
        result.look_z       = item_reg.target_z;
        result.cam_x        = sat32(34'(item_reg.target_x) - offx_reg);
        result.cam_y        = sat32(hy - offy_reg);
        result.cam_z        = sat32(34'(item_reg.target_z) - offz_reg);
        result.yaw_out      = yaw_reg;
        result.pitch_out    = pitch_reg;
        result.distance_out = dist_reg;
    end

    assign ready = (state_reg == ST_IDLE);
    assign done  = (state_reg == ST_DONE);

endmodule

// ----- hw/rtl/orbit_camera_follow.sv -----
// ----------------------------------------------------------------------------
// orbit_camera_follow: third-person orbit camera with smoothed distance
// Channel table:
//   channel   | direction | handshake           | payload
//   s_        | in        | s_tvalid / s_tready | s_tdata frame item, s_tuser flags
//   m_        | out       | m_tvalid / m_tready | m_tdata camera result
//   cfg_      | in        | cfg_we              | cfg_index, cfg_wdata
// One frame is paced by the shared multiplier: each of its 79 products (30
// with a zero spring rate) passes through an issue and a write-back state,
// plus the accept and hand-off states.
// A zero frame time is taken and dropped, leaving the core idle.
// Reset is synchronous on aresetn low; no clearing pass is needed.
// A stalled result waits in the output register; the core holds its finished
// frame until that register frees, and takes no frame while busy.
// ----------------------------------------------------------------------------
module orbit_camera_follow #(
    parameter int unsigned HEAD_HEIGHT     = 448,
    parameter int unsigned TRIG_TABLE_BITS = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // mouse_dx, mouse_dy, stick_x, stick_y, frame_time, vel_x, vel_z,
    // target_x, target_y, target_z
    input  logic [ocf_pkg::IN_W-1:0]    s_tdata,
    // has_movement, grounded
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // cam_x, cam_y, cam_z, look_x, look_y, look_z, yaw_out, pitch_out,
    // distance_out
    output logic [ocf_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [15:0]                 cfg_wdata
);

    ocf_pkg::cfg_t      cfg_reg;
    ocf_pkg::in_item_t  item;
    ocf_pkg::out_item_t result;
    ocf_pkg::out_item_t m_data_reg;
    logic               m_valid_reg;
    logic               core_ready;
    logic               core_done;
    logic               out_free;
    logic               dist_load;

    // unpack the input transaction
    assign item.mouse_dx     = s_tdata[15:0];
    assign item.mouse_dy     = s_tdata[31:16];
    assign item.stick_x      = s_tdata[47:32];
    assign item.stick_y      = s_tdata[63:48];
    assign item.frame_time   = s_tdata[79:64];
    assign item.vel_x        = s_tdata[95:80];
    assign item.vel_z        = s_tdata[111:96];
    assign item.target_x     = s_tdata[143:112];
    assign item.target_y     = s_tdata[175:144];
    assign item.target_z     = s_tdata[207:176];
    assign item.has_movement = s_tuser[0];
    assign item.grounded     = s_tuser[1];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mouse_sens_x    <= 13'sd21;
            cfg_reg.mouse_sens_y    <= 13'sd21;
            cfg_reg.stick_sens_x    <= 16'sd20861;
            cfg_reg.stick_sens_y    <= 16'sd20861;
            cfg_reg.pitch_low       <= -16'sd13000;
            cfg_reg.pitch_high      <= 16'sd13000;
            cfg_reg.spring_rate     <= 16'd2560;
            cfg_reg.manual_distance <= 16'd0;
        end else if (cfg_we) begin
            unique case (ocf_pkg::cfg_idx_t'(cfg_index))
                ocf_pkg::REG_MOUSE_SENS_X:    cfg_reg.mouse_sens_x    <= cfg_wdata[12:0];
                ocf_pkg::REG_MOUSE_SENS_Y:    cfg_reg.mouse_sens_y    <= cfg_wdata[12:0];
                ocf_pkg::REG_STICK_SENS_X:    cfg_reg.stick_sens_x    <= cfg_wdata;
                ocf_pkg::REG_STICK_SENS_Y:    cfg_reg.stick_sens_y    <= cfg_wdata;
                ocf_pkg::REG_PITCH_LOW:       cfg_reg.pitch_low       <= cfg_wdata;
                ocf_pkg::REG_PITCH_HIGH:      cfg_reg.pitch_high      <= cfg_wdata;
                ocf_pkg::REG_SPRING_RATE:     cfg_reg.spring_rate     <= cfg_wdata;
                ocf_pkg::REG_MANUAL_DISTANCE: cfg_reg.manual_distance <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a nonzero manual distance also jumps the smoothed distance while the core is idle
    assign dist_load = cfg_we && (ocf_pkg::cfg_idx_t'(cfg_index) == ocf_pkg::REG_MANUAL_DISTANCE)
                       && (cfg_wdata != 16'd0);

    assign out_free = !m_valid_reg || m_tready;

    ocf_core #(
        .HEAD_HEIGHT     (HEAD_HEIGHT),
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s_tvalid && core_ready),
        .item          (item),
        .cfg           (cfg_reg),
        .dist_load     (dist_load),
        .dist_load_val (cfg_wdata),
        .out_free      (out_free),
        .ready         (core_ready),
        .done          (core_done),
        .result        (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_done && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_done && out_free) begin
            m_data_reg <= result;
        end
    end

    assign s_tready = core_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.distance_out, m_data_reg.pitch_out, m_data_reg.yaw_out,
                       m_data_reg.look_z, m_data_reg.look_y, m_data_reg.look_x,
                       m_data_reg.cam_z, m_data_reg.cam_y, m_data_reg.cam_x};

`ifndef SYNTHESIS
    a_busy_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[79:64] != 16'd0) |=> !s_tready)
        else $error("core still ready after taking a frame");

    a_drop_zero_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[79:64] == 16'd0) |=> s_tready)
        else $error("zero frame time did not leave the core idle");

    a_result_from_core: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a frame in progress");

    a_core_holds_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (core_done && !out_free) |=> core_done)
        else $error("finished frame left the core before output freed");
`endif

endmodule
